// ===== rtl/acte_pkg.sv =====
package acte_pkg;

    localparam logic [7:0]  ASCII_ZERO       = 8'h30;
    localparam logic [7:0]  EPOCH_YEAR_SHIFT = 8'd30;
    localparam logic [15:0] DAYS_PER_YEAR    = 16'd365;
    localparam logic [18:0] SECS_PER_HOUR    = 19'd3600;
    localparam logic [18:0] SECS_PER_MIN     = 19'd60;
    localparam logic [32:0] SECS_PER_DAY     = 33'd86400;
    localparam logic [9:0]  MS_PER_HUNDRED   = 10'd100;
    localparam logic [9:0]  MS_PER_TEN       = 10'd10;
    localparam logic [6:0]  MONTHS_PER_YEAR  = 7'd12;
    localparam logic [6:0]  MONTH_MARCH      = 7'd3;
    localparam logic [1:0]  LEAP_PHASE       = 2'd2;

    localparam int DAYS_W = 16;
    localparam int SOD_W  = 19;
    localparam int MS_W   = 10;

    typedef struct packed {
        logic [15:0] year_chars;
        logic [15:0] month_chars;
        logic [15:0] day_chars;
        logic [15:0] hour_chars;
        logic [15:0] minute_chars;
        logic [15:0] second_chars;
        logic [23:0] milli_chars;
        logic        third_milli_digit;
    } acte_in_t;

    typedef struct packed {
        logic [31:0] epoch_seconds;
        logic [9:0]  milliseconds;
        logic        bad_input;
    } acte_out_t;

    typedef struct packed {
        logic [DAYS_W-1:0] days;
        logic [SOD_W-1:0]  sod;
        logic [MS_W-1:0]   ms;
        logic              bad;
    } acte_mid_t;

    // {bad, value}
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic ok;
        ok = (c >= ASCII_ZERO) && (c <= ASCII_ZERO + 8'd9);
        return ok ? {1'b0, 4'(c - ASCII_ZERO)} : 5'b1_0000;
    endfunction

    // {bad, value}
    function automatic logic [7:0] pair_of(input logic [15:0] v);
        logic [4:0] tens;
        logic [4:0] units;
        tens  = digit_of(v[15:8]);
        units = digit_of(v[7:0]);
        return {tens[4] | units[4], 7'(7'(tens[3:0]) * 7'd10 + 7'(units[3:0]))};
    endfunction

    function automatic logic [8:0] days_before_month(input logic [3:0] idx);
        logic [8:0] d;
        unique case (idx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/acte_decode.sv =====
module acte_decode
    import acte_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    input  acte_in_t  item,
    output logic      mid_valid,
    output acte_mid_t mid
);

    logic       valid_reg;
    acte_mid_t  mid_reg;
    acte_mid_t  mid_next;

    logic [7:0] yr_p;
    logic [7:0] mon_p;
    logic [7:0] day_p;
    logic [7:0] hr_p;
    logic [7:0] min_p;
    logic [7:0] sec_p;
    logic [4:0] ms_h;
    logic [4:0] ms_t;
    logic [4:0] ms_u;
    logic [7:0] years;
    logic       mon_bad;
    logic [3:0] mon_idx;
    logic       leap_add;

    always_comb
    begin
        yr_p  = pair_of(item.year_chars);
        mon_p = pair_of(item.month_chars);
        day_p = pair_of(item.day_chars);
        hr_p  = pair_of(item.hour_chars);
        min_p = pair_of(item.minute_chars);
        sec_p = pair_of(item.second_chars);
        ms_h  = digit_of(item.milli_chars[23:16]);
        ms_t  = digit_of(item.milli_chars[15:8]);
        ms_u  = digit_of(item.milli_chars[7:0]);

        years    = {1'b0, yr_p[6:0]} + EPOCH_YEAR_SHIFT;
        mon_bad  = (mon_p[6:0] == 7'd0) || (mon_p[6:0] > MONTHS_PER_YEAR);
        mon_idx  = 4'(mon_p[6:0] - 7'd1);
        leap_add = (years[1:0] == LEAP_PHASE) && (mon_p[6:0] >= MONTH_MARCH);

        mid_next.days = 16'(years) * DAYS_PER_YEAR
                      + 16'((years + 8'd1) >> 2)
                      + 16'(days_before_month(mon_idx))
                      + 16'(day_p[6:0])
                      + 16'(leap_add)
                      - 16'd1;
        mid_next.sod  = 19'(hr_p[6:0]) * SECS_PER_HOUR
                      + 19'(min_p[6:0]) * SECS_PER_MIN
                      + 19'(sec_p[6:0]);
        mid_next.ms   = 10'(ms_h[3:0]) * MS_PER_HUNDRED
                      + 10'(ms_t[3:0]) * MS_PER_TEN
                      + (item.third_milli_digit ? 10'(ms_u[3:0]) : 10'd0);
        mid_next.bad  = yr_p[7] | mon_p[7] | day_p[7] | hr_p[7] | min_p[7] | sec_p[7]
                      | ms_h[4] | ms_t[4] | (item.third_milli_digit & ms_u[4])
                      | mon_bad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid)
        begin
            mid_reg <= mid_next;
        end
    end

    assign mid_valid = valid_reg;
    assign mid       = mid_reg;

endmodule

// ===== rtl/acte_combine.sv =====
module acte_combine
    import acte_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      mid_valid,
    input  acte_mid_t mid,
    output logic      done,
    output acte_out_t result
);

    logic        done_reg;
    acte_out_t   result_reg;
    acte_out_t   result_next;
    logic [32:0] day_secs;

    always_comb
    begin
        day_secs = 33'(mid.days) * SECS_PER_DAY;
        if (mid.bad)
        begin
            result_next.epoch_seconds = 32'd0;
            result_next.milliseconds  = 10'd0;
            result_next.bad_input     = 1'b1;
        end
        else
        begin
            result_next.epoch_seconds = day_secs[31:0] + 32'(mid.sod);
            result_next.milliseconds  = mid.ms;
            result_next.bad_input     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= mid_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_valid)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/ascii_timestamp_to_epoch.sv =====
// Throughput: one transaction per cycle; busy stays low.
// Path: command register, decode/day-count register, day-to-seconds multiply and result register.
// Results are strobed for one cycle on done and cannot be stalled.
// Reset (rst_n low, asynchronous) clears all valid flags; in-flight transactions are dropped.
module ascii_timestamp_to_epoch
    import acte_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  acte_in_t  cmd,
    output logic      done,
    output acte_out_t result
);

    logic      cmd_valid_reg;
    acte_in_t  cmd_reg;
    logic      mid_valid;
    acte_mid_t mid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cmd_reg <= cmd;
        end
    end

    assign busy = 1'b0;

    acte_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (cmd_valid_reg),
        .item       (cmd_reg),
        .mid_valid  (mid_valid),
        .mid        (mid)
    );

    acte_combine u_combine (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_valid (mid_valid),
        .mid       (mid),
        .done      (done),
        .result    (result)
    );

endmodule

// ===== rtl/acte_checker.sv =====
module acte_checker
    import acte_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input acte_in_t  cmd,
    input logic      done,
    input acte_out_t result
);

    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("accepted transaction did not complete in 3 cycles");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##3 !done)
        else $error("done without an accepted transaction");

    a_bad_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.bad_input) |-> (result.epoch_seconds == 32'd0 &&
                                        result.milliseconds == 10'd0))
        else $error("bad transaction with nonzero fields");

    a_ms_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.milliseconds <= 10'd999))
        else $error("milliseconds out of range");

    a_month_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.month_chars[15:8] == ASCII_ZERO &&
         cmd.month_chars[7:0] == ASCII_ZERO) |-> ##3 (done && result.bad_input))
        else $error("month 00 not flagged");

endmodule

bind ascii_timestamp_to_epoch acte_checker u_acte_checker (.*);
